### hdl/gas_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gas_pkg: shared types and constants of the grid A* path search
// Grid geometry, cell marks, request codes, neighbour tables and item types.
// ----------------------------------------------------------------------------
package gas_pkg;

  // The grid width must be a power of two: a cell index is y * GRID_W + x.
  localparam int GRID_W     = 32;
  localparam int GRID_H     = 32;
  localparam int OPEN_DEPTH = 1024;
  localparam int NCELLS     = GRID_W * GRID_H;

  localparam int XW  = $clog2(GRID_W);
  localparam int YW  = $clog2(GRID_H);
  localparam int CW  = $clog2(NCELLS);
  localparam int QAW = $clog2(OPEN_DEPTH);
  localparam int QCW = $clog2(OPEN_DEPTH + 1);
  localparam int DW  = (XW > YW) ? XW : YW;

  localparam int GW = 14;
  localparam logic [GW-1:0] G_MAX = '1;
  localparam int H_SCALE = 100;
  localparam int FW = $clog2(int'(G_MAX) + H_SCALE * ((GRID_W - 1) * (GRID_W - 1) +
                             (GRID_H - 1) * (GRID_H - 1)) + 1);

  localparam int MW = 3;
  localparam logic [MW-1:0] MK_FREE    = 3'd0;
  localparam logic [MW-1:0] MK_BLOCKED = 3'd1;
  localparam logic [MW-1:0] MK_START   = 3'd2;
  localparam logic [MW-1:0] MK_GOAL    = 3'd3;
  localparam logic [MW-1:0] MK_OPEN    = 3'd4;
  localparam logic [MW-1:0] MK_CLOSED  = 3'd5;
  localparam logic [MW-1:0] MK_PATH    = 3'd6;

  localparam logic [1:0] REQ_WRITE  = 2'd0;
  localparam logic [1:0] REQ_START  = 2'd1;
  localparam logic [1:0] REQ_EXPAND = 2'd2;
  localparam logic [1:0] REQ_READ   = 2'd3;

  // Neighbour order NW, N, NE, W, E, SW, S, SE; offsets as two-bit signed codes.
  localparam logic [1:0] NB_DX [8] = '{2'b11, 2'b00, 2'b01, 2'b11, 2'b01, 2'b11, 2'b00, 2'b01};
  localparam logic [1:0] NB_DY [8] = '{2'b11, 2'b11, 2'b11, 2'b00, 2'b00, 2'b01, 2'b01, 2'b01};
  localparam logic [3:0] NB_COST [8] = '{4'd14, 4'd10, 4'd14, 4'd10,
                                         4'd10, 4'd14, 4'd10, 4'd14};

  typedef struct packed {
    logic [1:0] req_type;
    logic [4:0] cell_x;
    logic [4:0] cell_y;
    logic       blocked;
    logic [4:0] goal_x;
    logic [4:0] goal_y;
  } gas_req_t;

  typedef struct packed {
    logic        search_done;
    logic        path_found;
    logic [2:0]  cell_state;
    logic [10:0] open_size;
  } gas_rsp_t;

endpackage
`default_nettype wire

### hdl/gas_heur.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gas_heur: registered F = G + H cost unit
// H is the squared Euclidean distance to the goal, scaled by 100.
// ----------------------------------------------------------------------------
module gas_heur (
  input  wire logic                  clk_i,
  input  wire logic [gas_pkg::CW-1:0] cell_i,
  input  wire logic [gas_pkg::CW-1:0] goal_i,
  input  wire logic [gas_pkg::GW-1:0] g_i,
  output logic      [gas_pkg::FW-1:0] f_o
);
  import gas_pkg::*;

  logic [XW-1:0]     cx, gx, ax;
  logic [CW-XW-1:0]  cy, gy, ay;
  logic [2*DW:0]     sq_sum;
  logic [FW-1:0]     f_q;

  always_comb begin
    cx = cell_i[XW-1:0];
    gx = goal_i[XW-1:0];
    cy = cell_i[CW-1:XW];
    gy = goal_i[CW-1:XW];
    ax = (cx >= gx) ? (cx - gx) : (gx - cx);
    ay = (cy >= gy) ? (cy - gy) : (gy - cy);
    sq_sum = (2*DW+1)'((2*DW+1)'(ax) * (2*DW+1)'(ax)) +
             (2*DW+1)'((2*DW+1)'(ay) * (2*DW+1)'(ay));
  end

  always_ff @(posedge clk_i) begin
    f_q <= FW'(g_i) + FW'(FW'(sq_sum) * FW'(H_SCALE));
  end

  assign f_o = f_q;

endmodule
`default_nettype wire

### hdl/grid_astar_path_search.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grid_astar_path_search: A* search on an 8-connected grid, one expansion
// per expand request.
// ----------------------------------------------------------------------------
// Items enter on in_valid_i/in_ready_o and each gives exactly one result item
// on out_valid_o/out_ready_i. The block takes one item at a time under a
// sequencer; in_ready_o is high only while it is idle.
// A start request sweeps the cell marks, reading each cell and writing it
// free unless it is blocked, then marks the start and goal cells.
// An expansion pops the queue head and shifts the queue, then for each of
// the 8 neighbours may search the queue and insert in order, where each
// compared entry passes through the shared F unit; found paths are walked
// back cell by cell. All memory accesses go through single registered
// read ports.
// After reset a clearing pass writes every cell mark free, with in_ready_o
// low. A finished result waits in the output register; if the receiver
// stalls while a new result is ready, the block holds until the register
// is free.
// ----------------------------------------------------------------------------
module grid_astar_path_search (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire gas_pkg::gas_req_t in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output gas_pkg::gas_rsp_t      out_item_o
);
  import gas_pkg::*;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_DO, S_RD, S_ST_R, S_ST_W, S_ST_S, S_ST_G,
    S_EX_CUR, S_EX_G, S_RM_R, S_RM_W, S_NB, S_NB_M, S_NB_NX,
    S_SR_RQ, S_SR_C, S_SR_G, S_IN_CHK, S_IN_FN, S_IN_F0, S_IN_RQ,
    S_IN_RC, S_IN_F, S_IN_CMP, S_SH, S_SH_W, S_PT_W, S_PT_R, S_PT_END, S_RESP
  } state_e;

  state_e state_q;
  gas_req_t req_q;
  logic [QCW-1:0] cnt_q, ptr_q, pos_q;
  logic [CW-1:0]  start_q, goal_q, cur_q, n_q, e_q, pc_q, steps_q;
  logic [GW-1:0]  gcur_q, ng_q;
  logic [FW-1:0]  fnew_q;
  logic [2:0]     nb_q;
  logic           pop_q, ins_free_q;
  logic           rsp_done_q, rsp_found_q;
  logic [MW-1:0]  rsp_state_q;
  logic           out_valid_q;
  gas_rsp_t       out_q;

  // Memories.
  logic [MW-1:0] mark_mem [NCELLS];
  logic [GW-1:0] cost_mem [NCELLS];
  logic [CW-1:0] par_mem  [NCELLS];
  logic [CW-1:0] q_mem    [OPEN_DEPTH];

  logic           mk_we;  logic [CW-1:0] mk_wa, mk_ra; logic [MW-1:0] mk_wd, mk_rd_q;
  logic           cs_we;  logic [CW-1:0] cs_wa, cs_ra; logic [GW-1:0] cs_wd, cs_rd_q;
  logic           pr_we;  logic [CW-1:0] pr_wa, pr_ra; logic [CW-1:0] pr_wd, pr_rd_q;
  logic           q_we;   logic [QAW-1:0] q_wa, q_ra;  logic [CW-1:0] q_wd, q_rd_q;

  always_ff @(posedge clk_i) begin
    if (mk_we) mark_mem[mk_wa] <= mk_wd;
    mk_rd_q <= mark_mem[mk_ra];
  end
  always_ff @(posedge clk_i) begin
    if (cs_we) cost_mem[cs_wa] <= cs_wd;
    cs_rd_q <= cost_mem[cs_ra];
  end
  always_ff @(posedge clk_i) begin
    if (pr_we) par_mem[pr_wa] <= pr_wd;
    pr_rd_q <= par_mem[pr_ra];
  end
  always_ff @(posedge clk_i) begin
    if (q_we) q_mem[q_wa] <= q_wd;
    q_rd_q <= q_mem[q_ra];
  end

  // Shared F unit.
  logic [CW-1:0] h_cell;
  logic [GW-1:0] h_g;
  logic [FW-1:0] h_f;

  assign h_cell = (state_q == S_IN_FN) ? n_q : e_q;
  assign h_g    = (state_q == S_IN_FN) ? ng_q : cs_rd_q;

  gas_heur u_heur (
    .clk_i  (clk_i),
    .cell_i (h_cell),
    .goal_i (goal_q),
    .g_i    (h_g),
    .f_o    (h_f)
  );

  // Request decode.
  logic          in_grid, goal_in_grid;
  logic [CW-1:0] req_idx, req_goal;

  assign in_grid      = (int'(req_q.cell_x) < GRID_W) && (int'(req_q.cell_y) < GRID_H);
  assign goal_in_grid = (int'(req_q.goal_x) < GRID_W) && (int'(req_q.goal_y) < GRID_H);
  assign req_idx  = CW'(int'(req_q.cell_y) * GRID_W + int'(req_q.cell_x));
  assign req_goal = CW'(int'(req_q.goal_y) * GRID_W + int'(req_q.goal_x));

  // Neighbour of the current cell.
  logic [XW-1:0]    cx, nx;
  logic [CW-XW-1:0] cy, ny;
  logic [1:0]       dx, dy;
  logic             nb_out;
  logic [CW-1:0]    nb_cell;
  logic [GW:0]      ng_sum;
  logic [GW-1:0]    ng;

  always_comb begin
    cx = cur_q[XW-1:0];
    cy = cur_q[CW-1:XW];
    dx = NB_DX[nb_q];
    dy = NB_DY[nb_q];
    nb_out = (dx == 2'b11 && cx == '0) || (dx == 2'b01 && int'(cx) == GRID_W - 1) ||
             (dy == 2'b11 && cy == '0) || (dy == 2'b01 && int'(cy) == GRID_H - 1);
    nx = cx + {{(XW-1){dx[1]}}, dx[0]};
    ny = cy + {{(CW-XW-1){dy[1]}}, dy[0]};
    nb_cell = {ny, nx};
    ng_sum = (GW+1)'(gcur_q) + (GW+1)'(NB_COST[nb_q]);
    ng = (ng_sum > (GW+1)'(G_MAX)) ? G_MAX : ng_sum[GW-1:0];
  end

  logic ptr_next_lt_cnt;
  assign ptr_next_lt_cnt = ((QCW+1)'(ptr_q) + (QCW+1)'(1)) < (QCW+1)'(cnt_q);

  // Memory port control.
  always_comb begin
    mk_we = 1'b0; mk_wa = '0; mk_wd = MK_FREE; mk_ra = '0;
    cs_we = 1'b0; cs_wa = '0; cs_wd = '0;      cs_ra = '0;
    pr_we = 1'b0; pr_wa = '0; pr_wd = '0;      pr_ra = '0;
    q_we  = 1'b0; q_wa  = '0; q_wd  = '0;      q_ra  = '0;
    unique case (state_q)
      S_CLR: begin
        mk_we = 1'b1; mk_wa = steps_q; mk_wd = MK_FREE;
      end
      S_DO: begin
        if (req_q.req_type == REQ_WRITE && in_grid) begin
          mk_we = 1'b1; mk_wa = req_idx;
          mk_wd = req_q.blocked ? MK_BLOCKED : MK_FREE;
        end
        mk_ra = req_idx;
        q_ra  = '0;
      end
      S_ST_R: mk_ra = steps_q;
      S_ST_W: begin
        if (mk_rd_q != MK_BLOCKED) begin
          mk_we = 1'b1; mk_wa = steps_q; mk_wd = MK_FREE;
        end
      end
      S_ST_S: begin
        mk_we = 1'b1; mk_wa = start_q; mk_wd = MK_START;
        cs_we = 1'b1; cs_wa = start_q; cs_wd = '0;
        pr_we = 1'b1; pr_wa = start_q; pr_wd = start_q;
        q_we  = 1'b1; q_wa  = '0;      q_wd  = start_q;
      end
      S_ST_G: begin
        mk_we = 1'b1; mk_wa = goal_q; mk_wd = MK_GOAL;
      end
      S_EX_CUR: cs_ra = q_rd_q;
      S_RM_R: begin
        q_ra = QAW'(ptr_q + QCW'(1));
        if (!ptr_next_lt_cnt && !pop_q) begin
          cs_we = 1'b1; cs_wa = n_q; cs_wd = ng_q;
          pr_we = 1'b1; pr_wa = n_q; pr_wd = cur_q;
        end
      end
      S_RM_W: begin
        q_we = 1'b1; q_wa = QAW'(ptr_q); q_wd = q_rd_q;
      end
      S_NB: mk_ra = nb_cell;
      S_NB_M: begin
        if (mk_rd_q == MK_FREE) begin
          cs_we = 1'b1; cs_wa = n_q; cs_wd = ng_q;
          pr_we = 1'b1; pr_wa = n_q; pr_wd = cur_q;
        end
      end
      S_NB_NX: begin
        if (nb_q == 3'd7) begin
          mk_we = 1'b1; mk_wa = cur_q; mk_wd = MK_CLOSED;
        end
      end
      S_SR_RQ: q_ra = QAW'(ptr_q);
      S_SR_C:  cs_ra = n_q;
      S_IN_RQ: q_ra = QAW'(ptr_q);
      S_IN_RC: cs_ra = q_rd_q;
      S_SH: begin
        if (ptr_q > pos_q) begin
          q_ra = QAW'(ptr_q - QCW'(1));
        end else begin
          q_we = 1'b1; q_wa = QAW'(pos_q); q_wd = n_q;
          if (ins_free_q && n_q != start_q) begin
            mk_we = 1'b1; mk_wa = n_q; mk_wd = MK_OPEN;
          end
        end
      end
      S_SH_W: begin
        q_we = 1'b1; q_wa = QAW'(ptr_q); q_wd = q_rd_q;
      end
      S_PT_W: begin
        mk_we = 1'b1; mk_wa = pc_q; mk_wd = MK_PATH;
        pr_ra = pc_q;
      end
      S_PT_END: begin
        mk_we = 1'b1; mk_wa = start_q; mk_wd = MK_START;
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      cnt_q       <= '0;
      start_q     <= '0;
      goal_q      <= '0;
      steps_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_RESP && (!out_valid_q || out_ready_i)) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_CLR: begin
          steps_q <= steps_q + CW'(1);
          if (int'(steps_q) == NCELLS - 1) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid_i) begin
            req_q   <= in_item_i;
            state_q <= S_DO;
          end
        end
        S_DO: begin
          rsp_done_q  <= (req_q.req_type == REQ_EXPAND) && (cnt_q == '0);
          rsp_found_q <= 1'b0;
          rsp_state_q <= MK_FREE;
          unique case (req_q.req_type)
            REQ_WRITE: state_q <= S_RESP;
            REQ_READ:  state_q <= in_grid ? S_RD : S_RESP;
            REQ_START: begin
              if (in_grid && goal_in_grid) begin
                start_q <= req_idx;
                goal_q  <= req_goal;
                steps_q <= '0;
                state_q <= S_ST_R;
              end else begin
                state_q <= S_RESP;
              end
            end
            default: begin
              if (cnt_q == '0) begin
                state_q <= S_RESP;
              end else begin
                state_q <= S_EX_CUR;
              end
            end
          endcase
        end
        S_RD: begin
          rsp_state_q <= mk_rd_q;
          state_q     <= S_RESP;
        end
        S_ST_R: state_q <= S_ST_W;
        S_ST_W: begin
          steps_q <= steps_q + CW'(1);
          state_q <= (int'(steps_q) == NCELLS - 1) ? S_ST_S : S_ST_R;
        end
        S_ST_S: begin
          cnt_q   <= QCW'(1);
          state_q <= S_ST_G;
        end
        S_ST_G: state_q <= S_RESP;
        S_EX_CUR: begin
          cur_q   <= q_rd_q;
          state_q <= S_EX_G;
        end
        S_EX_G: begin
          gcur_q  <= cs_rd_q;
          ptr_q   <= '0;
          pop_q   <= 1'b1;
          nb_q    <= '0;
          state_q <= S_RM_R;
        end
        S_RM_R: begin
          if (ptr_next_lt_cnt) begin
            state_q <= S_RM_W;
          end else begin
            cnt_q   <= cnt_q - QCW'(1);
            state_q <= pop_q ? S_NB : S_IN_CHK;
          end
        end
        S_RM_W: begin
          ptr_q   <= ptr_q + QCW'(1);
          state_q <= S_RM_R;
        end
        S_NB: begin
          if (nb_out) begin
            state_q <= S_NB_NX;
          end else if (nb_cell == goal_q) begin
            pc_q    <= cur_q;
            steps_q <= '0;
            state_q <= S_PT_W;
          end else begin
            n_q     <= nb_cell;
            ng_q    <= ng;
            state_q <= S_NB_M;
          end
        end
        S_NB_M: begin
          if (mk_rd_q == MK_FREE) begin
            ins_free_q <= 1'b1;
            state_q    <= S_IN_CHK;
          end else if (mk_rd_q == MK_OPEN) begin
            ptr_q   <= '0;
            state_q <= S_SR_RQ;
          end else begin
            state_q <= S_NB_NX;
          end
        end
        S_NB_NX: begin
          if (nb_q == 3'd7) begin
            state_q <= S_RESP;
          end else begin
            nb_q    <= nb_q + 3'd1;
            state_q <= S_NB;
          end
        end
        S_SR_RQ: state_q <= (ptr_q < cnt_q) ? S_SR_C : S_NB_NX;
        S_SR_C: begin
          if (q_rd_q == n_q) begin
            state_q <= S_SR_G;
          end else begin
            ptr_q   <= ptr_q + QCW'(1);
            state_q <= S_SR_RQ;
          end
        end
        S_SR_G: begin
          if (ng_q < cs_rd_q) begin
            ins_free_q <= 1'b0;
            pop_q      <= 1'b0;
            state_q    <= S_RM_R;
          end else begin
            state_q <= S_NB_NX;
          end
        end
        S_IN_CHK: state_q <= (int'(cnt_q) >= OPEN_DEPTH) ? S_NB_NX : S_IN_FN;
        S_IN_FN:  state_q <= S_IN_F0;
        S_IN_F0: begin
          fnew_q <= h_f;
          ptr_q  <= '0;
          if (cnt_q != '0) begin
            state_q <= S_IN_RQ;
          end else begin
            pos_q   <= '0;
            state_q <= S_SH;
          end
        end
        S_IN_RQ: state_q <= S_IN_RC;
        S_IN_RC: begin
          e_q     <= q_rd_q;
          state_q <= S_IN_F;
        end
        S_IN_F: state_q <= S_IN_CMP;
        S_IN_CMP: begin
          if (h_f <= fnew_q && ptr_next_lt_cnt) begin
            ptr_q   <= ptr_q + QCW'(1);
            state_q <= S_IN_RQ;
          end else begin
            pos_q   <= (h_f <= fnew_q) ? ptr_q + QCW'(1) : ptr_q;
            ptr_q   <= cnt_q;
            state_q <= S_SH;
          end
        end
        S_SH: begin
          if (ptr_q > pos_q) begin
            state_q <= S_SH_W;
          end else begin
            cnt_q   <= cnt_q + QCW'(1);
            state_q <= S_NB_NX;
          end
        end
        S_SH_W: begin
          ptr_q   <= ptr_q - QCW'(1);
          state_q <= S_SH;
        end
        S_PT_W: begin
          steps_q <= steps_q + CW'(1);
          if (pc_q == start_q || int'(steps_q) == NCELLS - 1) state_q <= S_PT_END;
          else state_q <= S_PT_R;
        end
        S_PT_R: begin
          pc_q    <= pr_rd_q;
          state_q <= S_PT_W;
        end
        S_PT_END: begin
          rsp_done_q  <= 1'b1;
          rsp_found_q <= 1'b1;
          state_q     <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.search_done <= rsp_done_q;
            out_q.path_found  <= rsp_found_q;
            out_q.cell_state  <= rsp_state_q;
            out_q.open_size   <= 11'(cnt_q);
            state_q           <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // In the expand arm of S_DO an empty pop goes straight out; a real pop reads
  // the queue head, which S_DO already addresses.
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
`default_nettype wire
